FILE: sv/obrb_pkg.sv
// Shared types and constants for the overwriting byte ring buffer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package obrb_pkg;

   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int LEVEL_W = 9;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

   // Capacity after reset, before saturation to the store depth
   localparam logic [LEVEL_W-1:0] CAP_RESET = 9'd256;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // capture the request word and read the tail slot
      logic exec;   // perform the operation and register the result
   } obrb_cmd_type;

endpackage

FILE: sv/obrb_ctrl.sv
// Controller for the overwriting byte ring buffer: accept / execute sequencer.
// Depends on obrb_pkg for the command struct.
`timescale 1ns / 1ps

module obrb_ctrl
   import obrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output obrb_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Commands and status
   assign busy     = (state_ff == ST_EXEC);
   assign cmd.load = (state_ff == ST_IDLE) && start;
   assign cmd.exec = (state_ff == ST_EXEC);

endmodule

FILE: sv/obrb_dp.sv
// Datapath for the overwriting byte ring buffer: byte store, pointers, count,
// capacity register and result registers. Depends on obrb_pkg.
`timescale 1ns / 1ps

module obrb_dp
   import obrb_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  obrb_cmd_type       cmd,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [BYTE_W-1:0]  req_data,
   input  logic               csr_wr,
   input  logic [LEVEL_W-1:0] csr_wdata,
   output logic               rsp_valid,
   output logic [BYTE_W-1:0]  rsp_read_byte,
   output logic               rsp_success,
   output logic [LEVEL_W-1:0] rsp_fill_level,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [LEVEL_W-1:0] CAP_MAX = LEVEL_W'(DEPTH);

   // Advance a pointer with wrap at the effective capacity
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [LEVEL_W-1:0] cap);
      logic [LEVEL_W:0] n;
      n = (LEVEL_W+1)'(p) + 1'b1;
      return (n >= {1'b0, cap}) ? '0 : PTR_W'(n);
   endfunction

   logic [BYTE_W-1:0]  mem [DEPTH];
   logic [BYTE_W-1:0]  rd_byte_ff;
   logic [FUNC_W-1:0]  func_ff;
   logic [BYTE_W-1:0]  data_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [LEVEL_W-1:0] count_ff, count_in;
   logic [LEVEL_W-1:0] cap_ff, cap_in;
   logic               mem_we;
   logic [BYTE_W-1:0]  byte_in;
   logic               ok_in;
   logic               valid_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic               ok_ff;
   logic               empty_ff;
   logic               full_ff;

   // Effective capacity: zero taken as one, saturated to the store depth
   always_comb begin
      if (csr_wdata == '0)         cap_in = LEVEL_W'(1);
      else if (csr_wdata > CAP_MAX) cap_in = CAP_MAX;
      else                          cap_in = csr_wdata;
   end

   // Request capture and tail read at accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         data_ff    <= req_data;
         rd_byte_ff <= mem[tail_ff];
      end
   end

   // Store write
   always_ff @(posedge clock) begin
      if (mem_we) mem[head_ff] <= data_ff;
   end

   // Operation
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      mem_we   = 1'b0;
      byte_in  = '0;
      ok_in    = 1'b1;
      case (func_ff)
         FUNC_WRITE: begin
            mem_we  = cmd.exec;
            head_in = advance(head_ff, cap_ff);
            if (count_ff < cap_ff) count_in = count_ff + 1'b1;
            else                   tail_in  = advance(tail_ff, cap_ff);
         end
         FUNC_READ: begin
            if (count_ff == '0) begin
               ok_in = 1'b0;
            end else begin
               byte_in  = rd_byte_ff;
               tail_in  = advance(tail_ff, cap_ff);
               count_in = count_ff - 1'b1;
            end
         end
         FUNC_FLUSH: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= (CAP_RESET > CAP_MAX) ? CAP_MAX : CAP_RESET;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.exec;
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (csr_wr) cap_ff <= cap_in;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         byte_ff  <= byte_in;
         ok_ff    <= ok_in;
         empty_ff <= (count_in == '0);
         full_ff  <= (count_in == cap_ff);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_read_byte  = byte_ff;
   assign rsp_success    = ok_ff;
   assign rsp_fill_level = count_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_is_full    = full_ff;

endmodule

FILE: sv/overwriting_byte_ring_buffer_core.sv
// Overwriting byte ring buffer: each accepted word passes an accept and an execute
// state; busy is high in the execute state, so no new word is taken until idle again.
// The result strobe is registered from the execute state and rises alongside the next
// accept window. Synchronous active-high reset clears pointers, count and strobe and
// sets capacity to 256 (saturated to the depth); the store is not cleared. The receiver
// cannot stall.
`timescale 1ns / 1ps

module overwriting_byte_ring_buffer_core
   import obrb_pkg::*;
#(
   parameter int MAX_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [BYTE_W-1:0]  req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LEVEL_W-1:0] csr_wdata,
   output logic               rsp_valid,
   output logic [BYTE_W-1:0]  rsp_read_byte,
   output logic               rsp_success,
   output logic [LEVEL_W-1:0] rsp_fill_level,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   // Capacity never exceeds what the 9-bit register can name
   localparam int STORE_DEPTH = (MAX_DEPTH < 511) ? MAX_DEPTH : 511;

   obrb_cmd_type cmd;

   assign csr_ready = 1'b1;

   obrb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   obrb_dp #(
      .DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_data       (req_data),
      .csr_wr         (csr_valid && csr_ready),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_success    (rsp_success),
      .rsp_fill_level (rsp_fill_level),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for overwriting_byte_ring_buffer_core.
// Depends on obrb_pkg; predicts every result word and compares it field by field.
`timescale 1ns / 1ps

module tb_top;
   import obrb_pkg::*;

   localparam int DEPTH = 256;
   localparam int STALL_LIMIT = 200;
   localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;   // unused code, no operation

   // Expected status of one result word
   typedef struct packed {
      logic [BYTE_W-1:0]  rbyte;
      logic               ok;
      logic [LEVEL_W-1:0] level;
      logic               empty;
      logic               full;
   } buffer_status_type;

   // Operation mixes for the random traffic
   typedef enum int {MIX_FILL, MIX_WRITE_HEAVY, MIX_READ_HEAVY, MIX_BALANCED} op_mix_type;

   logic               clock;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   logic [FUNC_W-1:0]  req_func  = '0;
   logic [BYTE_W-1:0]  req_data  = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LEVEL_W-1:0] csr_wdata = '0;
   logic               rsp_valid;
   logic [BYTE_W-1:0]  rsp_read_byte;
   logic               rsp_success;
   logic [LEVEL_W-1:0] rsp_fill_level;
   logic               rsp_is_empty;
   logic               rsp_is_full;

   // Shadow copy of the buffer
   logic [BYTE_W-1:0]  shadow_store [DEPTH];
   bit                 shadow_written [DEPTH];
   int                 shadow_head;
   int                 shadow_tail;
   int                 shadow_count;
   logic [LEVEL_W-1:0] shadow_cap;

   buffer_status_type  pending_status [$];
   int                 mismatch_count = 0;
   bit                 no_gaps;
   int                 stall_cycles = 0;

   overwriting_byte_ring_buffer_core #(
      .MAX_DEPTH (DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_data       (req_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_success    (rsp_success),
      .rsp_fill_level (rsp_fill_level),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Capacity in use: zero counts as one, oversize saturates to the depth
   function automatic int eff_cap();
      int c;
      c = shadow_cap;
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int step_ptr(int p, int cap);
      return (p + 1 >= cap) ? 0 : p + 1;
   endfunction

   // Apply one operation to the shadow buffer and return the status word it gives
   function automatic buffer_status_type apply_buffer_op(logic [FUNC_W-1:0] op,
                                                         logic [BYTE_W-1:0] din);
      buffer_status_type st;
      int cap;
      cap = eff_cap();
      st = '0;
      st.ok = 1'b1;
      case (op)
         FUNC_WRITE: begin
            shadow_store[shadow_head] = din;
            shadow_written[shadow_head] = 1'b1;
            shadow_head = step_ptr(shadow_head, cap);
            if (shadow_count < cap) shadow_count++;
            else shadow_tail = step_ptr(shadow_tail, cap);
         end
         FUNC_READ: begin
            if (shadow_count == 0) begin
               st.ok = 1'b0;
            end else begin
               st.rbyte = shadow_store[shadow_tail];
               shadow_tail = step_ptr(shadow_tail, cap);
               shadow_count--;
            end
         end
         FUNC_FLUSH: begin
            shadow_head = 0;
            shadow_tail = 0;
            shadow_count = 0;
         end
         default: ;
      endcase
      st.level = shadow_count[LEVEL_W-1:0];
      st.empty = (shadow_count == 0);
      st.full  = (shadow_count == cap);
      return st;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
   endtask

   // Send one word; returns once it has been accepted
   task automatic send_word(input logic [FUNC_W-1:0] op, input logic [BYTE_W-1:0] din);
      req_func <= op;
      req_data <= din;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      pending_status.push_back(apply_buffer_op(op, din));
      if (!no_gaps && $urandom_range(99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drain outstanding results, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [LEVEL_W-1:0] cap);
      wait_idle();
      csr_wdata <= cap;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_cap = cap;
      @(posedge clock);
   endtask

   // Reads and flushes on an empty buffer, the unused code, then one write read back and a read on the emptied buffer
   task automatic test_empty_cases();
      send_word(FUNC_READ, 8'h00);
      send_word(FUNC_FLUSH, 8'hFF);
      send_word(FUNC_NOP, 8'hFF);
      send_word(FUNC_WRITE, 8'h00);
      send_word(FUNC_READ, 8'hFF);
      send_word(FUNC_READ, 8'h00);
   endtask

   // Overwrite of the oldest byte at a small capacity
   task automatic test_overwrite_small_capacity();
      set_capacity(9'd3);
      send_word(FUNC_WRITE, 8'hFF);
      send_word(FUNC_WRITE, 8'h01);
      send_word(FUNC_WRITE, 8'h02);
      send_word(FUNC_WRITE, 8'h03);
      repeat (4) send_word(FUNC_READ, 8'h00);
   endtask

   // Capacity zero acts as one, oversize saturates to the depth
   task automatic test_capacity_limits();
      set_capacity(9'd0);
      send_word(FUNC_WRITE, 8'hA5);
      send_word(FUNC_WRITE, 8'h5A);
      send_word(FUNC_READ, 8'h00);
      set_capacity(9'd511);
      send_word(FUNC_WRITE, 8'h3C);
      send_word(FUNC_READ, 8'h00);
   endtask

   // Lowering the capacity below the stored count keeps the count
   task automatic test_capacity_shrink();
      set_capacity(9'd256);
      send_word(FUNC_FLUSH, 8'h00);
      for (int i = 1; i <= 5; i++) send_word(FUNC_WRITE, 8'(i * 16));
      set_capacity(9'd2);
      send_word(FUNC_WRITE, 8'h99);
      repeat (3) send_word(FUNC_READ, 8'h00);
   endtask

   // Pick an operation for the given mix; a read that would hit a never-written
   // slot turns into a write
   function automatic logic [FUNC_W-1:0] pick_op(op_mix_type mix);
      int r;
      int wr_pct;
      int rd_pct;
      int fl_pct;
      logic [FUNC_W-1:0] op;
      r = $urandom_range(99);
      case (mix)
         MIX_FILL:        begin wr_pct = 90; rd_pct = 10; fl_pct = 0; end
         MIX_WRITE_HEAVY: begin wr_pct = 65; rd_pct = 27; fl_pct = 4; end
         MIX_READ_HEAVY:  begin wr_pct = 35; rd_pct = 57; fl_pct = 4; end
         default:         begin wr_pct = 48; rd_pct = 44; fl_pct = 4; end
      endcase
      if (r < wr_pct) op = FUNC_WRITE;
      else if (r < wr_pct + rd_pct) op = FUNC_READ;
      else if (r < wr_pct + rd_pct + fl_pct) op = FUNC_FLUSH;
      else op = FUNC_NOP;
      if (op == FUNC_READ && shadow_count != 0 && !shadow_written[shadow_tail])
         op = FUNC_WRITE;
      return op;
   endfunction

   // Random traffic over a series of capacities
   task automatic test_random_traffic();
      logic [LEVEL_W-1:0] cap;
      op_mix_type mix;
      int n_words;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0:       cap = 9'd256;
            1:       cap = 9'd1;
            2:       cap = 9'd2;
            3:       cap = 9'd0;
            4:       cap = 9'd511;
            5:       cap = 9'($urandom_range(257, 511));
            6, 7:    cap = 9'($urandom_range(3, 16));
            8:       cap = 9'd256;
            default: cap = 9'($urandom_range(0, 511));
         endcase
         set_capacity(cap);
         // first phase fills the full store with no gaps at all
         no_gaps = (phase == 0);
         mix = (phase == 0) ? MIX_FILL : op_mix_type'($urandom_range(1, 3));
         n_words = (phase == 0) ? 420 : 135;
         for (int i = 0; i < n_words; i++) send_word(pick_op(mix), 8'($urandom));
      end
      no_gaps = 1'b0;
   endtask

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin
      buffer_status_type want;
      if (!reset && rsp_valid) begin
         if (pending_status.size() == 0) begin
            report_mismatch("unexpected result word", rsp_fill_level, 0);
         end else begin
            want = pending_status.pop_front();
            if (rsp_read_byte !== want.rbyte)
               report_mismatch("read_byte", rsp_read_byte, want.rbyte);
            if (rsp_success !== want.ok)
               report_mismatch("success", rsp_success, want.ok);
            if (rsp_fill_level !== want.level)
               report_mismatch("fill_level", rsp_fill_level, want.level);
            if (rsp_is_empty !== want.empty)
               report_mismatch("is_empty", rsp_is_empty, want.empty);
            if (rsp_is_full !== want.full)
               report_mismatch("is_full", rsp_is_full, want.full);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      no_gaps = 1'b0;
      shadow_head = 0;
      shadow_tail = 0;
      shadow_count = 0;
      shadow_cap = CAP_RESET;
      for (int i = 0; i < DEPTH; i++) shadow_written[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_cases();
      test_overwrite_small_capacity();
      test_capacity_limits();
      test_capacity_shrink();
      test_random_traffic();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/obrb_pkg.sv
sv/obrb_ctrl.sv
sv/obrb_dp.sv
sv/overwriting_byte_ring_buffer_core.sv
verif/tb_top.sv
